### src/psc_pkg.sv
// shared types and constants for the pixel saturation and channel lut block
package psc_pkg;

  // fixed field widths
  localparam int unsigned CompW   = 8;
  localparam int unsigned GainW   = 11;
  localparam int unsigned GreyW   = 24;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  // rec.601 luma weights, q0.16, summing to 1.0
  localparam logic [15:0] LumaR = 16'd19595;
  localparam logic [15:0] LumaG = 16'd38470;
  localparam logic [15:0] LumaB = 16'd7471;

  // gain of 1.0 in q3.8 skips the saturation step
  localparam logic [GainW-1:0] GainOne = 11'd256;

  // item kinds carried in tuser
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_TABLE = 1'b1
  } psc_op_t;

  // table selector codes
  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2,
    CH_NONE  = 2'd3
  } psc_chan_t;

  // register index decoded from paddr[2]
  localparam logic RegGain = 1'b0;

  // one item as it moves through the pipeline
  typedef struct packed {
    psc_op_t     op;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    psc_chan_t   tbl_ch;
    logic [7:0]  tbl_idx;
    logic [7:0]  tbl_val;
  } psc_item_t;

endpackage

### src/pixel_saturation_and_channel_lut.sv
// path: an item is registered at input, luma, gain multiply, clamp and table read
// throughput: one item per cycle unless out_tready stalls, as each step sits in its
//   own register stage; the tables have one write and one read port
// reset: clears all valid bits and sets the gain to 1.0 (bypass); table contents
//   are undefined until written
module pixel_saturation_and_channel_lut (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // red_in[7:0], green_in[15:8], blue_in[23:16], table_channel[25:24],
  // table_index[33:26], table_value[41:34], zero pad[47:42]
  input  logic [psc_pkg::InDataW-1:0]   in_tdata,
  // opcode[0]
  input  logic [0:0]                    in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [psc_pkg::OutDataW-1:0]  out_tdata,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import psc_pkg::*;

  logic [GainW-1:0] gain;
  psc_item_t        in_item, sat_item;
  logic             sat_valid, lut_ready;
  logic [7:0]       red_o, green_o, blue_o;

  // unpack the input transfer
  assign in_item.op      = psc_op_t'(in_tuser[0]);
  assign in_item.red     = in_tdata[7:0];
  assign in_item.green   = in_tdata[15:8];
  assign in_item.blue    = in_tdata[23:16];
  assign in_item.tbl_ch  = psc_chan_t'(in_tdata[25:24]);
  assign in_item.tbl_idx = in_tdata[33:26];
  assign in_item.tbl_val = in_tdata[41:34];

  psc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .gain    (gain)
  );

  psc_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .gain      (gain),
    .out_valid (sat_valid),
    .out_ready (lut_ready),
    .out_item  (sat_item)
  );

  psc_lut u_lut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sat_valid),
    .in_ready  (lut_ready),
    .in_item   (sat_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red_out   (red_o),
    .green_out (green_o),
    .blue_out  (blue_o)
  );

  // pack the result transfer
  assign out_tdata = {blue_o, green_o, red_o};

endmodule

### src/psc_cfg.sv
// apb register file holding the saturation gain
module psc_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [psc_pkg::GainW-1:0] gain
);
  import psc_pkg::*;

  logic [GainW-1:0] gain_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // gain register, 1.0 after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GainOne;
    end else if (wr_en && (paddr[2] == RegGain)) begin
      gain_r <= pwdata[GainW-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegGain) begin
      prdata = {{(32-GainW){1'b0}}, gain_r};
    end
  end

  assign gain = gain_r;

endmodule

### src/psc_sat.sv
// four-stage saturation pipeline: input, luma, gain multiply, clamp
module psc_sat (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  psc_pkg::psc_item_t        in_item,
  input  logic [psc_pkg::GainW-1:0] gain,
  output logic                      out_valid,
  input  logic                      out_ready,
  output psc_pkg::psc_item_t        out_item
);
  import psc_pkg::*;

  // clamp a signed q.24 value to an 8-bit component
  function automatic logic [7:0] clamp_comp(input logic signed [36:0] v);
    logic [7:0] res;
    if (v[36]) begin
      res = 8'd0;
    end else if (|v[35:32]) begin
      res = 8'd255;
    end else begin
      res = v[31:24];
    end
    return res;
  endfunction

  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy0, rdy1, rdy2, rdy3;
  psc_item_t item0_r, item1_r, item2_r, item3_r;
  logic [GreyW-1:0] grey1_r, grey2_r, grey_nxt;
  logic signed [24:0] diff_red, diff_green, diff_blue;
  logic signed [11:0] gain_s;
  logic signed [35:0] prod_red_r, prod_green_r, prod_blue_r;
  logic signed [35:0] prod_red_nxt, prod_green_nxt, prod_blue_nxt;
  logic signed [36:0] grey_sh, sum_red, sum_green, sum_blue;
  psc_item_t item3_nxt;

  // ready chain lets bubbles collapse
  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;
  assign in_ready = rdy0;

  // luma
  assign grey_nxt = 24'(LumaR) * 24'(item0_r.red) + 24'(LumaG) * 24'(item0_r.green)
                  + 24'(LumaB) * 24'(item0_r.blue);

  // component minus luma, then times gain
  assign diff_red   = $signed({1'b0, item1_r.red, 16'd0})   - $signed({1'b0, grey1_r});
  assign diff_green = $signed({1'b0, item1_r.green, 16'd0}) - $signed({1'b0, grey1_r});
  assign diff_blue  = $signed({1'b0, item1_r.blue, 16'd0})  - $signed({1'b0, grey1_r});
  assign gain_s = $signed({1'b0, gain});
  assign prod_red_nxt   = 36'(gain_s) * 36'(diff_red);
  assign prod_green_nxt = 36'(gain_s) * 36'(diff_green);
  assign prod_blue_nxt  = 36'(gain_s) * 36'(diff_blue);

  // add scaled luma, floor and clamp, or bypass at unity gain
  assign grey_sh   = $signed({5'd0, grey2_r, 8'd0});
  assign sum_red   = grey_sh + 37'(prod_red_r);
  assign sum_green = grey_sh + 37'(prod_green_r);
  assign sum_blue  = grey_sh + 37'(prod_blue_r);

  always_comb begin
    item3_nxt = item2_r;
    if (gain != GainOne) begin
      item3_nxt.red   = clamp_comp(sum_red);
      item3_nxt.green = clamp_comp(sum_green);
      item3_nxt.blue  = clamp_comp(sum_blue);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      item0_r <= in_item;
    end
    if (v0_r && rdy1) begin
      item1_r <= item0_r;
      grey1_r <= grey_nxt;
    end
    if (v1_r && rdy2) begin
      item2_r      <= item1_r;
      grey2_r      <= grey1_r;
      prod_red_r   <= prod_red_nxt;
      prod_green_r <= prod_green_nxt;
      prod_blue_r  <= prod_blue_nxt;
    end
    if (v2_r && rdy3) begin
      item3_r <= item3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_item  = item3_r;

endmodule

### src/psc_lut.sv
// per-channel lookup tables and the output register
module psc_lut (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  psc_pkg::psc_item_t      in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              red_out,
  output logic [7:0]              green_out,
  output logic [7:0]              blue_out
);
  import psc_pkg::*;

  logic [7:0] mem_red   [0:TableDepth-1];
  logic [7:0] mem_green [0:TableDepth-1];
  logic [7:0] mem_blue  [0:TableDepth-1];
  logic [7:0] rd_red_r, rd_green_r, rd_blue_r;
  logic       out_valid_r;
  logic       mv, is_wr;

  assign in_ready = !out_valid_r || out_ready;
  assign mv       = in_valid && in_ready;
  assign is_wr    = mv && (in_item.op == OP_TABLE);

  // table writes, taken in stream order
  always_ff @(posedge clk) begin
    if (is_wr && (in_item.tbl_ch == CH_RED))   mem_red[in_item.tbl_idx]   <= in_item.tbl_val;
    if (is_wr && (in_item.tbl_ch == CH_GREEN)) mem_green[in_item.tbl_idx] <= in_item.tbl_val;
    if (is_wr && (in_item.tbl_ch == CH_BLUE))  mem_blue[in_item.tbl_idx]  <= in_item.tbl_val;
  end

  // registered reads form the output data
  always_ff @(posedge clk) begin
    if (mv) begin
      rd_red_r   <= mem_red[in_item.red];
      rd_green_r <= mem_green[in_item.green];
      rd_blue_r  <= mem_blue[in_item.blue];
    end
  end

  // only pixel items produce a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid && (in_item.op == OP_PIXEL);
    end
  end

  assign out_valid = out_valid_r;
  assign red_out   = rd_red_r;
  assign green_out = rd_green_r;
  assign blue_out  = rd_blue_r;

endmodule

### tb/sv/tb.sv
// testbench for the pixel saturation and channel lut block: directed table plus random phases
`timescale 1ns / 100ps

module tb;
  import psc_pkg::*;

  // luma weights and gain values kept apart from the design package
  localparam int unsigned WeightR = 19595;
  localparam int unsigned WeightG = 38470;
  localparam int unsigned WeightB = 7471;
  localparam logic [10:0] UnityGain = 11'd256;
  localparam logic [2:0] GainAddr = 3'd0;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned DrainLimit = 20000;
  localparam int unsigned PhaseItems = 34;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PrintCap = 100;
  localparam realtime TimeoutNs = 2_000_000;

  // one graded pixel, red in the low byte as on out_tdata
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } graded_pixel_t;

  // one line of the directed stimulus
  typedef struct packed {
    bit            set_gain;
    logic [10:0]   gain;
    psc_op_t       op;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    psc_chan_t     ch;
    logic [7:0]    idx;
    logic [7:0]    val;
    bit            typed;
    graded_pixel_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // red_in[7:0], green_in[15:8], blue_in[23:16], table_channel[25:24],
  // table_index[33:26], table_value[41:34], zero pad[47:42]
  logic [InDataW-1:0] in_tdata = '0;
  // opcode[0]
  logic [0:0]  in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  logic [OutDataW-1:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state: gain shadow and table mirror
  logic [10:0] sat_gain = UnityGain;
  logic [7:0]  lut_mirror [3][256];
  bit          lut_written [3][256];
  graded_pixel_t graded_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned table_writes = 0;
  int unsigned gains_used = 0;

  // directed stimulus, table written first so typed results are easy to read
  dir_row_t dir_rows [25] = '{
    '{1'b0, 11'd0,    OP_TABLE, 8'hFF, 8'hFF, 8'hFF, CH_RED,   8'h00, 8'h11, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_TABLE, 8'h00, 8'h00, 8'h00, CH_GREEN, 8'h00, 8'h22, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_TABLE, 8'h00, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h33, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_TABLE, 8'h00, 8'h00, 8'h00, CH_RED,   8'hFF, 8'hA5, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_TABLE, 8'h00, 8'h00, 8'h00, CH_GREEN, 8'hFF, 8'h5A, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_TABLE, 8'h00, 8'h00, 8'h00, CH_BLUE,  8'hFF, 8'hC3, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b1, 24'h332211},
    '{1'b0, 11'd0,    OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, CH_BLUE,  8'h00, 8'h00, 1'b1, 24'hC35AA5},
    // write to the unused fourth table is dropped
    '{1'b0, 11'd0,    OP_TABLE, 8'h80, 8'h40, 8'h20, CH_NONE,  8'h00, 8'hFF, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_PIXEL, 8'h00, 8'h00, 8'h00, CH_NONE,  8'hFF, 8'hFF, 1'b1, 24'h332211},
    '{1'b0, 11'd0,    OP_PIXEL, 8'hFF, 8'h00, 8'hFF, CH_RED,   8'hFF, 8'h00, 1'b1, 24'hC322A5},
    '{1'b0, 11'd0,    OP_TABLE, 8'h00, 8'h00, 8'h00, CH_RED,   8'h00, 8'h00, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_PIXEL, 8'h00, 8'hFF, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b1, 24'h335A00},
    // zero gain: every channel collapses to grey
    '{1'b1, 11'd0,    OP_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, CH_BLUE,  8'h00, 8'h00, 1'b1, 24'hC35AA5},
    '{1'b0, 11'd0,    OP_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b1, 24'h332200},
    '{1'b0, 11'd0,    OP_PIXEL, 8'hFF, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b0, 24'h0},
    // top of range, clamps both ways
    '{1'b1, 11'd1024, OP_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_PIXEL, 8'hFF, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b1, 24'h3322A5},
    '{1'b0, 11'd0,    OP_PIXEL, 8'h00, 8'hFF, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b0, 24'h0},
    // gain above the nominal range
    '{1'b1, 11'd2047, OP_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_PIXEL, 8'h00, 8'h00, 8'hFF, CH_BLUE,  8'h00, 8'h00, 1'b1, 24'hC32200},
    '{1'b0, 11'd0,    OP_PIXEL, 8'h80, 8'h40, 8'hC8, CH_BLUE,  8'h00, 8'h00, 1'b0, 24'h0},
    // just above unity, saturation step active
    '{1'b1, 11'd257,  OP_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,  8'h00, 8'h00, 1'b0, 24'h0},
    '{1'b0, 11'd0,    OP_PIXEL, 8'hC8, 8'h64, 8'h32, CH_BLUE,  8'h00, 8'h00, 1'b0, 24'h0}
  };

  pixel_saturation_and_channel_lut DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  task automatic flag_mismatch(string msg);
    if (fail_count < PrintCap) $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // grey + gain*(c - grey) in q.24, floored and clamped to a byte
  function automatic logic [7:0] stretch_comp(logic [23:0] grey, logic [7:0] c,
                                              logic [10:0] gain);
    longint spread;
    longint acc;
    spread = (longint'(c) <<< 16) - longint'(grey);
    acc = longint'(grey) * 256 + longint'(gain) * spread;
    if (acc < 0) return 8'd0;
    if (acc > 64'sd4294967295) return 8'hFF;
    return acc[31:24];
  endfunction

  // table indices after the saturation step
  function automatic graded_pixel_t saturate_px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    graded_pixel_t px;
    logic [23:0] grey;
    px.red = r;
    px.green = g;
    px.blue = b;
    if (sat_gain != UnityGain) begin
      grey = 24'(WeightR * r + WeightG * g + WeightB * b);
      px.red = stretch_comp(grey, r, sat_gain);
      px.green = stretch_comp(grey, g, sat_gain);
      px.blue = stretch_comp(grey, b, sat_gain);
    end
    return px;
  endfunction

  function automatic graded_pixel_t grade_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    graded_pixel_t ix;
    graded_pixel_t px;
    ix = saturate_px(r, g, b);
    px.red = lut_mirror[CH_RED][ix.red];
    px.green = lut_mirror[CH_GREEN][ix.green];
    px.blue = lut_mirror[CH_BLUE][ix.blue];
    return px;
  endfunction

  function automatic logic [7:0] pick_comp();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one input transfer; the prediction is made once it is accepted
  task automatic send_item(psc_op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           psc_chan_t ch, logic [7:0] idx, logic [7:0] val,
                           bit typed, graded_pixel_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, val, idx, ch, b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_TABLE) begin
      table_writes++;
      if (ch != CH_NONE) begin
        lut_mirror[ch][idx] = val;
        lut_written[ch][idx] = 1'b1;
      end
    end else begin
      graded_q.push_back(typed ? want : grade_pixel(r, g, b));
      pixels_sent++;
    end
  endtask

  // write any table entry the next pixel will read; refresh also rewrites some
  task automatic prime_lut(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit refresh);
    graded_pixel_t ix;
    logic [7:0] slot;
    psc_chan_t ch;
    ix = saturate_px(r, g, b);
    for (int k = 0; k < 3; k++) begin
      ch = psc_chan_t'(2'(k));
      slot = (ch == CH_RED) ? ix.red : (ch == CH_GREEN) ? ix.green : ix.blue;
      if (!lut_written[ch][slot] || (refresh && $urandom_range(9) == 0))
        send_item(OP_TABLE, pick_comp(), pick_comp(), pick_comp(), ch, slot,
                  8'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  // stop sending, wait for every graded pixel, then let table writes settle
  task automatic quiesce();
    int unsigned waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (graded_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // setup then access phase; read data sampled mid access
  task automatic apb_xfer(bit wr, logic [2:0] addr, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
      @(negedge clk);
    end
    rdata = cfg_prdata;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_gain(logic [10:0] gain);
    logic [31:0] rd;
    quiesce();
    apb_xfer(1'b1, GainAddr, {21'd0, gain}, rd);
    sat_gain = gain;
    gains_used++;
    apb_xfer(1'b0, GainAddr, '0, rd);
    if (rd != {21'd0, gain})
      flag_mismatch($sformatf("gain readback %0d, wrote %0d", rd, gain));
  endtask

  // result side: compare each transfer, then pick the next ready
  always @(posedge clk) begin : result_check
    graded_pixel_t got;
    graded_pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = graded_pixel_t'(out_tdata);
      if (graded_q.size() == 0) begin
        flag_mismatch($sformatf("pixel %h with none pending", out_tdata));
      end else begin
        want = graded_q.pop_front();
        pixels_checked++;
        if (got.red != want.red)
          flag_mismatch($sformatf("red %h, want %h", got.red, want.red));
        if (got.green != want.green)
          flag_mismatch($sformatf("green %h, want %h", got.green, want.green));
        if (got.blue != want.blue)
          flag_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : stimulus
    logic [31:0] rd;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [10:0] gain;
    dir_row_t row;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // gain comes out of reset at unity
    apb_xfer(1'b0, GainAddr, '0, rd);
    if (rd != {21'd0, UnityGain})
      flag_mismatch($sformatf("gain after reset %0d", rd));

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.set_gain) begin
        apply_gain(row.gain);
      end else begin
        if (row.op == OP_PIXEL && !row.typed) prime_lut(row.r, row.g, row.b, 1'b0);
        send_item(row.op, row.r, row.g, row.b, row.ch, row.idx, row.val, row.typed, row.want);
      end
    end

    // random phases, each with its own gain and idle pattern
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: gain = 11'd0;
        1: gain = 11'd1024;
        2: gain = 11'd2047;
        3: gain = UnityGain;
        4: gain = 11'($urandom_range(1, 255));
        5: gain = 11'd255;
        6: gain = 11'd257;
        default: gain = 11'($urandom_range(1025, 2046));
      endcase
      apply_gain(gain);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        // hold off mid phase until the output side has caught up
        if (k == PhaseItems / 2) quiesce();
        if ($urandom_range(99) < 25) begin
          send_item(OP_TABLE, pick_comp(), pick_comp(), pick_comp(),
                    psc_chan_t'(2'($urandom_range(3))), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'b0, '0);
        end else begin
          r = pick_comp();
          g = pick_comp();
          b = pick_comp();
          prime_lut(r, g, b, 1'b1);
          send_item(OP_PIXEL, r, g, b, psc_chan_t'(2'($urandom_range(3))),
                    8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
        end
      end
    end

    quiesce();
    if (graded_q.size() != 0)
      flag_mismatch($sformatf("%0d graded pixels never arrived", graded_q.size()));
    $display("covered %0d pixel transfers (%0d checked) and %0d table writes",
             pixels_sent, pixels_checked, table_writes);
    $display("over %0d gain settings from zero to full scale, with idle and stall mixes",
             gains_used);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop if a transfer never completes
  initial begin : watchdog
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule
